[design/lu_matrix_inverse_top_assert.svh]
// Assertion macros used by the matrix inverse top level
`ifndef LU_MATRIX_INVERSE_TOP_ASSERT_SVH
`define LU_MATRIX_INVERSE_TOP_ASSERT_SVH

// Implication checked every clock, ignored during reset
`define LMI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked every clock, ignored during reset
`define LMI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/lmi_pkg.sv]
// ----------------------------------------------------------------------------
// lmi_pkg
// Shared constants, types and arithmetic helpers for the LU matrix inverse.
// ----------------------------------------------------------------------------
package lmi_pkg;

   localparam int MaxSize   = 8;
   localparam int IdxW      = $clog2(MaxSize);
   localparam int AddrW     = 2 * IdxW;
   localparam int FracBits  = 16;
   localparam int WordW     = 32;
   localparam int AccW      = 48;
   localparam int QuoW      = WordW + FracBits + 1;
   localparam int DivStepW  = $clog2(QuoW + 1);

   typedef logic signed [WordW-1:0] word_type;
   typedef logic signed [AccW-1:0]  acc_type;

   // Control sequencer states
   typedef enum logic [4:0] {
      ST_LOAD,
      ST_D_RD,     // issue read of L(i,k), or of the target entry
      ST_D_MAC,    // issue read of U(k,j); register L(i,k)
      ST_D_ACC,    // multiply L(i,k) by U(k,j)
      ST_D_FIN,    // read pivot; register target entry
      ST_D_PIV,    // form numerator, check pivot
      ST_D_NUM,    // accumulate product
      ST_D_DIV,    // start divider
      ST_D_WR,     // write back
      ST_CHK_RD,
      ST_CHK,
      ST_I_RD,
      ST_I_MAC,
      ST_I_ACC,
      ST_I_PIV,
      ST_I_NUM,
      ST_I_DIV,
      ST_I_WR,
      ST_OUT_RD,
      ST_OUT
   } state_type;

   // Saturate a 48-bit value to a 32-bit word
   function automatic word_type sat32(input acc_type v);
      acc_type wmax;
      acc_type wmin;
      wmax = acc_type'(signed'({1'b0, {(WordW-1){1'b1}}}));
      wmin = -wmax - acc_type'(1);
      if (v > wmax)      sat32 = {1'b0, {(WordW-1){1'b1}}};
      else if (v < wmin) sat32 = {1'b1, {(WordW-1){1'b0}}};
      else               sat32 = v[WordW-1:0];
   endfunction

   // Saturating 48-bit add of a rescaled product
   function automatic acc_type acc_add(input acc_type a, input acc_type p);
      logic signed [AccW:0] s;
      s = {a[AccW-1], a} + {p[AccW-1], p};
      if (s[AccW] != s[AccW-1])
         acc_add = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
      else
         acc_add = s[AccW-1:0];
   endfunction

endpackage

[design/lmi_divider.sv]
// ----------------------------------------------------------------------------
// lmi_divider
// Restoring divider, one quotient bit per cycle: (num << 16) / den,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module lmi_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  lmi_pkg::word_type   num,
   input  lmi_pkg::word_type   den,
   output logic                done,
   output lmi_pkg::word_type   quo
);

   localparam int QW = lmi_pkg::QuoW;

   logic [QW-1:0]                 dvd_ff, dvd_in;
   logic [lmi_pkg::WordW:0]       rem_ff, rem_in;
   logic [lmi_pkg::WordW:0]       den_ff, den_in;
   logic                          neg_ff, neg_in;
   logic [lmi_pkg::DivStepW-1:0]  cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   logic [lmi_pkg::WordW:0]       shifted;
   logic [lmi_pkg::WordW+1:0]     trial;
   logic [QW-1:0]                 mag_num;

   always_comb begin
      mag_num = num[lmi_pkg::WordW-1] ? QW'(-{{(QW-lmi_pkg::WordW){num[lmi_pkg::WordW-1]}},
                num}) : QW'({{(QW-lmi_pkg::WordW){1'b0}}, num});
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[lmi_pkg::WordW-1:0], dvd_ff[QW-1]};
      trial   = {1'b0, shifted} - {1'b0, den_ff};
      // load operands as magnitudes
      if (start) begin
         dvd_in  = mag_num << lmi_pkg::FracBits;
         rem_in  = '0;
         den_in  = den[lmi_pkg::WordW-1] ? (lmi_pkg::WordW+1)'(-{den[lmi_pkg::WordW-1], den})
                                         : {1'b0, den};
         neg_in  = num[lmi_pkg::WordW-1] ^ den[lmi_pkg::WordW-1];
         cnt_in  = lmi_pkg::DivStepW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // advance one quotient bit
         if (!trial[lmi_pkg::WordW+1]) begin
            rem_in = trial[lmi_pkg::WordW:0];
            dvd_in = {dvd_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            dvd_in = {dvd_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == lmi_pkg::DivStepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // sign and saturate the finished quotient magnitude
   always_comb begin
      if (!neg_ff && (dvd_ff > QW'(32'h7FFF_FFFF)))
         quo = {1'b0, {(lmi_pkg::WordW-1){1'b1}}};
      else if (neg_ff && (dvd_ff > QW'(32'h8000_0000)))
         quo = {1'b1, {(lmi_pkg::WordW-1){1'b0}}};
      else if (neg_ff)
         quo = -dvd_ff[lmi_pkg::WordW-1:0];
      else
         quo = dvd_ff[lmi_pkg::WordW-1:0];
   end
   assign done = done_ff;

endmodule

[design/lu_matrix_inverse_top.sv]
// ----------------------------------------------------------------------------
// lu_matrix_inverse_top
// Fixed-point matrix inverse through Doolittle LU factoring in place.
// ----------------------------------------------------------------------------
//  channel | ports                                  | handshake
//  --------+----------------------------------------+--------------------------
//  request | req_element                            | start & !busy
//  result  | rsp_inverse_element, rsp_row,          | rsp_valid, one cycle,
//          | rsp_column, rsp_singular, rsp_last     | no backpressure
//  config  | csr_matrix_size                        | csr_write
//
//  A non-final element is written to the factor store. The last element
//  starts the solve: every multiply-accumulate runs through one shared
//  multiplier, and each of the N^2 quotients through the bit-serial divider,
//  all against two memories with one read and one write port each. Then
//  follow N^2 result beats, each read from the inverse store before it is
//  sent. busy stays high from the last element to the last result beat.
//  Reset is synchronous and clears control; memories are undefined until loaded.
// ----------------------------------------------------------------------------
`include "lu_matrix_inverse_top_assert.svh"

module lu_matrix_inverse_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_element,
   input  logic                csr_write,
   input  logic [3:0]          csr_matrix_size,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_inverse_element,
   output logic [2:0]          rsp_row,
   output logic [2:0]          rsp_column,
   output logic                rsp_singular,
   output logic                rsp_last
);

   localparam int IW = lmi_pkg::IdxW;
   localparam int AW = lmi_pkg::AddrW;

   // storage
   lmi_pkg::word_type lu_mem  [lmi_pkg::MaxSize*lmi_pkg::MaxSize];
   lmi_pkg::word_type inv_mem [lmi_pkg::MaxSize*lmi_pkg::MaxSize];

   lmi_pkg::state_type st_ff, st_in;
   logic [3:0]    size_ff, size_in;
   logic [IW-1:0] lr_ff, lr_in, lc_ff, lc_in;     // load position
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic          sing_ff, sing_in;
   lmi_pkg::acc_type acc_ff, acc_in;
   lmi_pkg::word_type a_ff, b_ff;                 // registered memory data
   logic signed [63:0] prod_ff, prod_in;
   lmi_pkg::word_type num_ff, num_in;
   logic          div_start;
   logic          div_done;
   lmi_pkg::word_type div_q;

   // effective order, clamped to 1..MaxSize
   logic [IW:0]   n;
   logic [IW-1:0] nm1;
   always_comb begin
      if (size_ff == 4'd0)                      n = (IW+1)'(1);
      else if (size_ff > 4'(lmi_pkg::MaxSize))  n = (IW+1)'(lmi_pkg::MaxSize);
      else                                      n = size_ff[IW:0];
      nm1 = IW'(n - 1'b1);
   end

   // memory port controls
   logic          lu_we, inv_we;
   logic [AW-1:0] lu_wa, lu_ra, inv_wa, inv_ra;
   lmi_pkg::word_type lu_wd, inv_wd;
   lmi_pkg::word_type lu_rd_ff, inv_rd_ff;

   always_ff @(posedge clock) begin
      if (lu_we)  lu_mem[lu_wa]   <= lu_wd;
      if (inv_we) inv_mem[inv_wa] <= inv_wd;
      lu_rd_ff  <= lu_mem[lu_ra];
      inv_rd_ff <= inv_mem[inv_ra];
   end

   lmi_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (b_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   function automatic logic [AW-1:0] adr(input logic [IW-1:0] r, input logic [IW-1:0] c);
      adr = {r, c};
   endfunction

   logic last_ld;
   logic [IW-1:0] lim;
   logic signed [63:0] shp;
   lmi_pkg::acc_type   prod_s;
   lmi_pkg::acc_type   num_w;
   // kind of inverse entry: diagonal, upper, lower
   logic diag, upper;

   assign last_ld = (lr_ff == nm1) && (lc_ff == nm1);
   assign diag    = (i_ff == j_ff);
   assign upper   = (i_ff < j_ff);
   assign lim     = (i_ff <= j_ff) ? i_ff : j_ff;
   assign shp     = prod_ff >>> lmi_pkg::FracBits;
   // saturate the rescaled product into the 48-bit range
   always_comb begin
      if (shp > 64'sh0000_7FFF_FFFF_FFFF)       prod_s = {1'b0, {47{1'b1}}};
      else if (shp < -64'sh0000_8000_0000_0000) prod_s = {1'b1, {47{1'b0}}};
      else                                      prod_s = shp[47:0];
   end

   always_comb begin
      st_in     = st_ff;
      size_in   = size_ff;
      lr_in     = lr_ff;
      lc_in     = lc_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      sing_in   = sing_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      num_in    = num_ff;
      div_start = 1'b0;
      lu_we     = 1'b0;
      inv_we    = 1'b0;
      lu_wa     = adr(i_ff, j_ff);
      inv_wa    = adr(i_ff, j_ff);
      lu_wd     = '0;
      inv_wd    = '0;
      lu_ra     = adr(i_ff, k_ff);
      inv_ra    = adr(k_ff, j_ff);
      num_w     = '0;
      busy      = (st_ff != lmi_pkg::ST_LOAD);
      rsp_valid = 1'b0;

      unique case (st_ff)
         lmi_pkg::ST_LOAD: begin
            // store one element per beat
            if (csr_write) begin
               size_in = csr_matrix_size;
               lr_in   = '0;
               lc_in   = '0;
            end else if (start) begin
               lu_we = 1'b1;
               lu_wa = adr(lr_ff, lc_ff);
               lu_wd = req_element;
               if (lc_ff == nm1) begin
                  lc_in = '0;
                  lr_in = (lr_ff == nm1) ? '0 : lr_ff + 1'b1;
               end else begin
                  lc_in = lc_ff + 1'b1;
               end
               if (last_ld) begin
                  st_in  = lmi_pkg::ST_D_RD;
                  i_in   = '0;
                  j_in   = '0;
                  k_in   = '0;
                  acc_in = '0;
                  sing_in = 1'b0;
               end
            end
         end
         lmi_pkg::ST_D_RD: begin
            // read L(i,k) while terms remain, else the target entry
            if ({1'b0, k_ff} < {1'b0, lim}) begin
               lu_ra = adr(i_ff, k_ff);
               st_in = lmi_pkg::ST_D_MAC;
            end else begin
               lu_ra = adr(i_ff, j_ff);
               st_in = lmi_pkg::ST_D_FIN;
            end
         end
         lmi_pkg::ST_D_MAC: begin
            lu_ra = adr(k_ff, j_ff);
            st_in = lmi_pkg::ST_D_ACC;
         end
         lmi_pkg::ST_D_ACC: begin
            // a_ff holds L(i,k), lu_rd_ff U(k,j)
            prod_in = 64'(a_ff) * 64'(lu_rd_ff);
            st_in   = lmi_pkg::ST_D_NUM;
            k_in    = k_ff + 1'b1;
         end
         lmi_pkg::ST_D_NUM: begin
            acc_in = lmi_pkg::acc_add(acc_ff, prod_s);
            st_in  = lmi_pkg::ST_D_RD;
         end
         lmi_pkg::ST_D_FIN: begin
            lu_ra = adr(j_ff, j_ff);
            st_in = lmi_pkg::ST_D_PIV;
         end
         lmi_pkg::ST_D_PIV: begin
            // a_ff = target entry, lu_rd_ff = pivot
            num_w  = lmi_pkg::acc_type'(a_ff) - acc_ff;
            num_in = lmi_pkg::sat32(num_w);
            if (i_ff <= j_ff) begin
               st_in = lmi_pkg::ST_D_WR;
            end else if (lu_rd_ff == '0) begin
               sing_in = 1'b1;
               st_in   = lmi_pkg::ST_OUT_RD;
               i_in    = '0;
               j_in    = '0;
            end else begin
               st_in = lmi_pkg::ST_D_DIV;
            end
         end
         lmi_pkg::ST_D_DIV: begin
            div_start = 1'b1;
            st_in     = lmi_pkg::ST_D_WR;
         end
         lmi_pkg::ST_D_WR: begin
            if (i_ff <= j_ff || div_done) begin
               lu_we  = 1'b1;
               lu_wd  = (i_ff <= j_ff) ? num_ff : div_q;
               acc_in = '0;
               k_in   = '0;
               if (j_ff == nm1) begin
                  j_in = '0;
                  if (i_ff == nm1) begin
                     i_in  = '0;
                     st_in = lmi_pkg::ST_CHK_RD;
                  end else begin
                     i_in  = i_ff + 1'b1;
                     st_in = lmi_pkg::ST_D_RD;
                  end
               end else begin
                  j_in  = j_ff + 1'b1;
                  st_in = lmi_pkg::ST_D_RD;
               end
            end
         end
         lmi_pkg::ST_CHK_RD: begin
            lu_ra = adr(i_ff, i_ff);
            st_in = lmi_pkg::ST_CHK;
         end
         lmi_pkg::ST_CHK: begin
            // scan U diagonal for a zero pivot
            if (lu_rd_ff == '0) begin
               sing_in = 1'b1;
               i_in    = '0;
               j_in    = '0;
               st_in   = lmi_pkg::ST_OUT_RD;
            end else if (i_ff == nm1) begin
               // last diagonal entry has no terms to sum
               i_in   = nm1;
               j_in   = nm1;
               k_in   = nm1 + 1'b1;
               acc_in = '0;
               st_in  = lmi_pkg::ST_I_PIV;
            end else begin
               i_in  = i_ff + 1'b1;
               st_in = lmi_pkg::ST_CHK_RD;
            end
         end
         lmi_pkg::ST_I_RD: begin
            // p runs from min(i,j)+1 through n-1; k_ff is p
            if (diag || upper) begin
               lu_ra  = adr(i_ff, k_ff);
               inv_ra = adr(k_ff, j_ff);
            end else begin
               inv_ra = adr(i_ff, k_ff);
               lu_ra  = adr(k_ff, j_ff);
            end
            st_in = lmi_pkg::ST_I_MAC;
         end
         lmi_pkg::ST_I_MAC: begin
            prod_in = 64'(lu_rd_ff) * 64'(inv_rd_ff);
            st_in   = lmi_pkg::ST_I_ACC;
         end
         lmi_pkg::ST_I_ACC: begin
            acc_in = lmi_pkg::acc_add(acc_ff, prod_s);
            if (k_ff == nm1) st_in = lmi_pkg::ST_I_PIV;
            else begin
               k_in  = k_ff + 1'b1;
               st_in = lmi_pkg::ST_I_RD;
            end
         end
         lmi_pkg::ST_I_PIV: begin
            lu_ra = adr(i_ff, i_ff);
            st_in = lmi_pkg::ST_I_NUM;
         end
         lmi_pkg::ST_I_NUM: begin
            num_w  = diag ? (lmi_pkg::acc_type'(1) <<< lmi_pkg::FracBits) - acc_ff : -acc_ff;
            num_in = lmi_pkg::sat32(num_w);
            st_in  = (diag || upper) ? lmi_pkg::ST_I_DIV : lmi_pkg::ST_I_WR;
         end
         lmi_pkg::ST_I_DIV: begin
            div_start = 1'b1;
            st_in     = lmi_pkg::ST_I_WR;
         end
         lmi_pkg::ST_I_WR: begin
            if (!(diag || upper) || div_done) begin
               inv_we = 1'b1;
               inv_wd = (diag || upper) ? div_q : num_ff;
               acc_in = '0;
               if (j_ff == '0) begin
                  if (i_ff == '0) begin
                     st_in = lmi_pkg::ST_OUT_RD;
                  end else begin
                     i_in = i_ff - 1'b1;
                     j_in = nm1;
                  end
               end else begin
                  j_in = j_ff - 1'b1;
               end
               // next entry's first p
               if (!(j_ff == '0 && i_ff == '0)) begin
                  if (j_ff == '0) begin
                     k_in  = (i_ff - 1'b1 < nm1) ? i_ff : nm1;
                     st_in = (i_ff - 1'b1 < nm1) ? lmi_pkg::ST_I_RD : lmi_pkg::ST_I_PIV;
                  end else begin
                     k_in  = (((j_ff - 1'b1) < i_ff) ? (j_ff - 1'b1) : i_ff) + 1'b1;
                     st_in = ((((j_ff - 1'b1) < i_ff) ? (j_ff - 1'b1) : i_ff) < nm1)
                             ? lmi_pkg::ST_I_RD : lmi_pkg::ST_I_PIV;
                  end
               end else begin
                  i_in = '0;
                  j_in = '0;
               end
            end
         end
         lmi_pkg::ST_OUT_RD: begin
            inv_ra = adr(i_ff, j_ff);
            st_in  = lmi_pkg::ST_OUT;
         end
         lmi_pkg::ST_OUT: begin
            // send one result beat
            rsp_valid = 1'b1;
            if (j_ff == nm1) begin
               j_in = '0;
               if (i_ff == nm1) begin
                  i_in  = '0;
                  st_in = lmi_pkg::ST_LOAD;
               end else begin
                  i_in  = i_ff + 1'b1;
                  st_in = lmi_pkg::ST_OUT_RD;
               end
            end else begin
               j_in  = j_ff + 1'b1;
               st_in = lmi_pkg::ST_OUT_RD;
            end
         end
         default: st_in = lmi_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= lmi_pkg::ST_LOAD;
         size_ff <= 4'(lmi_pkg::MaxSize);
         lr_ff   <= '0;
         lc_ff   <= '0;
         i_ff    <= '0;
         j_ff    <= '0;
         k_ff    <= '0;
         sing_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         size_ff <= size_in;
         lr_ff   <= lr_in;
         lc_ff   <= lc_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         k_ff    <= k_in;
         sing_ff <= sing_in;
      end
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      // hold operand or target read in the previous state; pivot goes to divisor
      if (st_ff == lmi_pkg::ST_D_MAC || st_ff == lmi_pkg::ST_D_FIN) a_ff <= lu_rd_ff;
      if (st_ff == lmi_pkg::ST_D_PIV || st_ff == lmi_pkg::ST_I_NUM) b_ff <= lu_rd_ff;
   end

   assign rsp_inverse_element = sing_ff ? '0 : inv_rd_ff;
   assign rsp_row      = i_ff;
   assign rsp_column   = j_ff;
   assign rsp_singular = sing_ff;
   assign rsp_last     = rsp_valid && (i_ff == nm1) && (j_ff == nm1);

   `LMI_ASSERT_IMP(a_no_out_in_load, clock, reset, st_ff == lmi_pkg::ST_LOAD, !rsp_valid,
      "result beat while loading")
   `LMI_ASSERT_IMP(a_last_valid, clock, reset, rsp_last, rsp_valid, "last without beat")
   `LMI_ASSERT_NEXT(a_last_idle, clock, reset, rsp_last, !busy, "busy after last beat")
   `LMI_ASSERT_IMP(a_no_write_mix, clock, reset, lu_we && st_ff == lmi_pkg::ST_LOAD,
      !inv_we, "both stores written in load")

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lu_matrix_inverse_top. Streams matrices of many
// orders and shapes (full-range random, well conditioned, singular, small),
// rewrites the order between phases, and compares every inverse beat with
// an independent fixed-point LU solve kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  MaxSize   = lmi_pkg::MaxSize;
   localparam int  FracBits  = lmi_pkg::FracBits;
   localparam int  IdleLimit = 200000;
   localparam longint Q_ONE  = 64'sd65536;
   localparam longint W_MAX  = 64'sd2147483647;
   localparam longint W_MIN  = -64'sd2147483648;
   localparam longint S_MAX  = (64'sd1 <<< 47) - 1;
   localparam longint S_MIN  = -(64'sd1 <<< 47);

   typedef struct {
      logic signed [31:0] value;
      logic [2:0]         row;
      logic [2:0]         column;
      logic               singular;
      logic               last;
   } inverse_beat_type;

   // ------------------------------------------------------------------
   // Scoreboard: predicts the inverse of each loaded matrix
   // ------------------------------------------------------------------
   class inverse_scoreboard;
      longint        lu[MaxSize*MaxSize];
      longint        inv[MaxSize*MaxSize];
      int unsigned   order_reg;
      int unsigned   fill_count;
      inverse_beat_type expected_beats[$];
      int            error_count;

      function new();
         order_reg   = MaxSize;
         fill_count  = 0;
         error_count = 0;
      endfunction

      function int unsigned order();
         if (order_reg < 1) return 1;
         if (order_reg > MaxSize) return MaxSize;
         return order_reg;
      endfunction

      function void set_size(logic [3:0] v);
         order_reg  = v;
         fill_count = 0;
      endfunction

      function longint clip32(longint v);
         if (v > W_MAX) return W_MAX;
         if (v < W_MIN) return W_MIN;
         return v;
      endfunction

      function longint mac(longint acc, longint a, longint b);
         longint s;
         s = acc + ((a * b) >>> FracBits);
         if (s > S_MAX) return S_MAX;
         if (s < S_MIN) return S_MIN;
         return s;
      endfunction

      function longint quot(longint num, longint d);
         return clip32((num * Q_ONE) / d);
      endfunction

      // Factor in place; return 0 on a zero pivot
      function bit factor(int n);
         longint acc;
         int lim;
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               acc = 0;
               lim = (i <= j) ? i : j;
               for (int k = 0; k < lim; k++)
                  acc = mac(acc, lu[i*MaxSize+k], lu[k*MaxSize+j]);
               if (i <= j) begin
                  lu[i*MaxSize+j] = clip32(lu[i*MaxSize+j] - acc);
               end else begin
                  if (lu[j*MaxSize+j] == 0) return 0;
                  lu[i*MaxSize+j] = quot(clip32(lu[i*MaxSize+j] - acc),
                                         lu[j*MaxSize+j]);
               end
            end
         end
         for (int i = 0; i < n; i++)
            if (lu[i*MaxSize+i] == 0) return 0;
         return 1;
      endfunction

      // Back substitution from the last row and column upward
      function void back_solve(int n);
         longint acc;
         for (int i = n - 1; i >= 0; i--) begin
            for (int j = n - 1; j >= 0; j--) begin
               acc = 0;
               if (i == j) begin
                  for (int p = j + 1; p < n; p++)
                     acc = mac(acc, lu[j*MaxSize+p], inv[p*MaxSize+j]);
                  inv[j*MaxSize+j] = quot(clip32(Q_ONE - acc), lu[j*MaxSize+j]);
               end else if (i < j) begin
                  for (int p = i + 1; p < n; p++)
                     acc = mac(acc, lu[i*MaxSize+p], inv[p*MaxSize+j]);
                  inv[i*MaxSize+j] = quot(clip32(-acc), lu[i*MaxSize+i]);
               end else begin
                  for (int p = j + 1; p < n; p++)
                     acc = mac(acc, inv[i*MaxSize+p], lu[p*MaxSize+j]);
                  inv[i*MaxSize+j] = clip32(-acc);
               end
            end
         end
      endfunction

      // Note one accepted element beat
      function void note_element(logic signed [31:0] v);
         int n;
         bit ok;
         inverse_beat_type b;
         n = order();
         if (fill_count >= n*n) fill_count = 0;
         lu[(fill_count / n)*MaxSize + (fill_count % n)] = longint'(v);
         fill_count++;
         if (fill_count < n*n) return;
         fill_count = 0;
         ok = factor(n);
         if (ok) back_solve(n);
         for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               b.value    = ok ? inv[r*MaxSize+c][31:0] : 32'sd0;
               b.row      = 3'(r);
               b.column   = 3'(c);
               b.singular = !ok;
               b.last     = (r == n - 1) && (c == n - 1);
               expected_beats.push_back(b);
            end
         end
      endfunction

      // Check one result beat against the oldest expectation
      function void check_result(inverse_beat_type got);
         inverse_beat_type want;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat value=%0d row=%0d col=%0d",
                     $realtime, got.value, got.row, got.column);
            error_count++;
            return;
         end
         want = expected_beats.pop_front();
         if (got.value !== want.value) begin
            $display("%0t: inverse_element expected %0d actual %0d (r%0d c%0d)",
                     $realtime, want.value, got.value, want.row, want.column);
            error_count++;
         end
         if (got.row !== want.row) begin
            $display("%0t: row expected %0d actual %0d", $realtime, want.row, got.row);
            error_count++;
         end
         if (got.column !== want.column) begin
            $display("%0t: column expected %0d actual %0d",
                     $realtime, want.column, got.column);
            error_count++;
         end
         if (got.singular !== want.singular) begin
            $display("%0t: singular expected %0b actual %0b",
                     $realtime, want.singular, got.singular);
            error_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $realtime, want.last, got.last);
            error_count++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // DUT and clock
   // ------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_element = '0;
   logic               csr_write = 1'b0;
   logic [3:0]         csr_matrix_size = 4'd8;
   logic               rsp_valid;
   logic signed [31:0] rsp_inverse_element;
   logic [2:0]         rsp_row;
   logic [2:0]         rsp_column;
   logic               rsp_singular;
   logic               rsp_last;

   lu_matrix_inverse_top DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_element         (req_element),
      .csr_write           (csr_write),
      .csr_matrix_size     (csr_matrix_size),
      .rsp_valid           (rsp_valid),
      .rsp_inverse_element (rsp_inverse_element),
      .rsp_row             (rsp_row),
      .rsp_column          (rsp_column),
      .rsp_singular        (rsp_singular),
      .rsp_last            (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   inverse_scoreboard sb = new();
   int idle_cycles  = 0;
   int elements_sent = 0;
   int burst_left   = 0;

   // ------------------------------------------------------------------
   // Monitor: note accepted beats, check results, watch for a hang
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      inverse_beat_type got;
      bit active;
      if (!reset) begin
         active = 1'b0;
         if (csr_write) begin
            sb.set_size(csr_matrix_size);
            active = 1'b1;
         end
         if (start && !busy) begin
            sb.note_element(req_element);
            active = 1'b1;
         end
         if (rsp_valid) begin
            got.value    = rsp_inverse_element;
            got.row      = rsp_row;
            got.column   = rsp_column;
            got.singular = rsp_singular;
            got.last     = rsp_last;
            sb.check_result(got);
            active = 1'b1;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("FAILURE");
            $finish;
         end
         idle_cycles <= active ? 0 : idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // Hold off until every expected beat has come and the block is idle
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (sb.expected_beats.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(logic [3:0] v);
      drain();
      csr_write       <= 1'b1;
      csr_matrix_size <= v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Drive one element beat; when bursty, with bursts and random gaps in between
   task automatic send_element(logic signed [31:0] v, bit bursty);
      if (bursty) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         burst_left--;
      end
      start       <= 1'b1;
      req_element <= v;
      do @(posedge clock); while (busy);
      elements_sent++;
   endtask

   // Send a whole matrix of the current order, or only part of it
   task automatic send_matrix(int shape, int count, bit bursty);
      int n;
      int zero_row;
      logic signed [31:0] v;
      n = sb.order();
      zero_row = $urandom_range(0, n - 1);
      for (int idx = 0; idx < count; idx++) begin
         case (shape)
            0: v = $urandom;
            1, 2: begin
               if (idx / n == idx % n) begin
                  v = (n * 4 + $urandom_range(1, 8)) <<< 16;
                  v = v + $urandom_range(0, 65535);
                  if ($urandom_range(0, 1)) v = -v;
               end else begin
                  v = $urandom_range(0, 4 << 16) - (2 << 16);
               end
               if (shape == 2 && idx / n == zero_row) v = 0;
            end
            default: v = $urandom_range(0, 8 << 16) - (4 << 16);
         endcase
         send_element(v, bursty);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int n;
      int shape;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: order one extremes, order zero and above range
      write_size(4'd1);
      send_element(32'sh0000_0000, 0);
      send_element(32'sh7fff_ffff, 0);
      send_element(32'sh8000_0000, 0);
      send_element(32'sh0001_0000, 0);
      send_element(-32'sd1, 0);
      send_element(32'sd1, 0);
      write_size(4'd0);
      send_element(32'sh0002_0000, 0);
      write_size(4'd2);
      send_element(32'sh0001_0000, 0);
      send_element(32'sh0000_0000, 0);
      send_element(32'sh0000_0000, 0);
      send_element(32'sh0001_0000, 0);
      // final pivot zero only
      send_element(32'sh0001_0000, 0);
      send_element(32'sh0001_0000, 0);
      send_element(32'sh0001_0000, 0);
      send_element(32'sh0001_0000, 0);
      write_size(4'd15);
      send_matrix(1, 64, 0);
      // restart loading partway through
      write_size(4'd3);
      send_matrix(0, 4, 0);
      write_size(4'd3);
      send_matrix(2, 9, 0);

      // Random phase: mostly small orders, few of the largest
      while (elements_sent < 300) begin
         case ($urandom_range(0, 9))
            0:       write_size($urandom_range(0, 1) ? 4'd8 : 4'($urandom_range(9, 15)));
            1:       write_size(4'd0);
            2, 3, 4: write_size(4'($urandom_range(1, 2)));
            default: write_size(4'($urandom_range(3, 5)));
         endcase
         n = sb.order();
         repeat ($urandom_range(1, (n > 4) ? 1 : 3)) begin
            shape = $urandom_range(0, 9);
            shape = (shape < 5) ? 1 : (shape < 7) ? 0 : (shape < 8) ? 2 : 3;
            if ($urandom_range(0, 14) == 0)
               send_matrix(shape, $urandom_range(1, n*n), 1);
            else
               send_matrix(shape, n*n, $urandom_range(0, 3) != 0);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_beats.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
